// File: sv/bh_pkg.sv
// ----------------------------------------------------------------------------
// bh_pkg
// Shared types and defaults for the byte histogram core.
// ----------------------------------------------------------------------------
package bh_pkg;

  localparam int SymbolCountDefault = 256;
  localparam int CountWidthDefault  = 32;
  localparam int ByteWidth          = 8;
  localparam int OutCountWidth      = 32;

  localparam logic ActCount  = 1'b0;
  localparam logic ActReport = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_CNT_UPD = 4'b0010,
    S_RPT_SYM = 4'b0100,
    S_RPT_CNT = 4'b1000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_count;
    logic update_count;
    logic load_empty;
    logic read_count_sym;
    logic finish_report;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic byte_seen;
    logic table_empty;
    logic out_free;
  } status_t;

endpackage

// File: sv/bh_ram.sv
// ----------------------------------------------------------------------------
// bh_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bh_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/bh_ctrl.sv
// ----------------------------------------------------------------------------
// bh_ctrl
// Sequencer for count and report transfers.
// ----------------------------------------------------------------------------
module bh_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_action_i,
  output logic            in_ready_o,
  input  bh_pkg::status_t status_i,
  output bh_pkg::ctrl_t   ctrl_o
);
  import bh_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) && status_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_action_i == ActCount) begin
            ctrl_o.load_count = 1'b1;
            if (status_i.byte_seen) state_d = S_CNT_UPD;
          end else if (status_i.table_empty) begin
            ctrl_o.load_empty = 1'b1;
          end else begin
            state_d = S_RPT_SYM;
          end
        end
      end
      S_CNT_UPD: begin
        ctrl_o.update_count = 1'b1;
        state_d = S_IDLE;
      end
      S_RPT_SYM: begin
        ctrl_o.read_count_sym = 1'b1;
        state_d = S_RPT_CNT;
      end
      S_RPT_CNT: begin
        ctrl_o.finish_report = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/bh_datapath.sv
// ----------------------------------------------------------------------------
// bh_datapath
// Seen map, count and appearance memories, list pointers, result register.
// ----------------------------------------------------------------------------
module bh_datapath #(
  parameter int ALPHABET_SIZE = bh_pkg::SymbolCountDefault,
  parameter int COUNT_WIDTH   = bh_pkg::CountWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [bh_pkg::ByteWidth-1:0]   byte_i,
  input  bh_pkg::ctrl_t                  ctrl_i,
  output bh_pkg::status_t                status_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bh_pkg::ByteWidth-1:0]   out_symbol_o,
  output logic [bh_pkg::OutCountWidth-1:0] out_count_o,
  output logic                           out_valid_res_o,
  output logic                           out_last_o
);
  import bh_pkg::*;

  localparam int IdxW = $clog2(ALPHABET_SIZE);
  localparam int TotW = $clog2(ALPHABET_SIZE + 1);

  logic [ALPHABET_SIZE-1:0] seen_q, seen_d;
  logic [TotW-1:0]         total_q, total_d;
  logic [TotW-1:0]         pos_q, pos_d;
  logic [IdxW-1:0]         byte_addr_q;
  logic                    out_valid_q, out_valid_d;
  logic [ByteWidth-1:0]    sym_q;
  logic [ByteWidth-1:0]    res_symbol_q;
  logic [OutCountWidth-1:0] res_count_q;
  logic                    res_valid_q, res_last_q;

  logic [IdxW-1:0]        byte_addr;
  logic                   byte_ok, new_sym, is_last;
  logic [TotW-1:0]        slot;
  logic                   cnt_we;
  logic [IdxW-1:0]        cnt_waddr, cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
  logic [ByteWidth-1:0]   ord_rdata;
  logic [OutCountWidth-1:0] cnt_clip;

  assign byte_addr = byte_i[IdxW-1:0];
  assign byte_ok   = (byte_i != '0) && ({1'b0, byte_i} < 9'(ALPHABET_SIZE));
  assign new_sym   = ctrl_i.load_count && byte_ok && !seen_q[byte_addr];
  assign slot      = total_q - pos_q - TotW'(1);
  assign is_last   = (pos_q + TotW'(1)) == total_q;

  assign status_o.byte_seen   = byte_ok && seen_q[byte_addr];
  assign status_o.table_empty = pos_q >= total_q;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign cnt_we    = new_sym || ctrl_i.update_count;
  assign cnt_waddr = ctrl_i.update_count ? byte_addr_q : byte_addr;
  assign cnt_wdata = ctrl_i.update_count ?
                     ((&cnt_rdata) ? cnt_rdata : cnt_rdata + COUNT_WIDTH'(1)) :
                     COUNT_WIDTH'(1);
  assign cnt_raddr = ctrl_i.read_count_sym ? ord_rdata[IdxW-1:0] : byte_addr;

  bh_ram #(.Width(COUNT_WIDTH), .Depth(ALPHABET_SIZE)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  bh_ram #(.Width(ByteWidth), .Depth(ALPHABET_SIZE)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (new_sym && (total_q < TotW'(ALPHABET_SIZE))),
    .waddr_i (total_q[IdxW-1:0]),
    .wdata_i (byte_i),
    .raddr_i (slot[IdxW-1:0]),
    .rdata_o (ord_rdata)
  );

  if (COUNT_WIDTH > OutCountWidth) begin : g_clip
    assign cnt_clip = (|cnt_rdata[COUNT_WIDTH-1:OutCountWidth]) ? '1 :
                      cnt_rdata[OutCountWidth-1:0];
  end else begin : g_ext
    assign cnt_clip = OutCountWidth'(cnt_rdata);
  end

  always_comb begin
    seen_d      = seen_q;
    total_d     = total_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (ctrl_i.load_count) pos_d = '0;
    if (new_sym) begin
      seen_d[byte_addr] = 1'b1;
      total_d           = total_q + TotW'(1);
    end
    if (ctrl_i.load_empty) out_valid_d = 1'b1;
    if (ctrl_i.finish_report) begin
      out_valid_d = 1'b1;
      if (is_last) begin
        seen_d  = '0;
        total_d = '0;
        pos_d   = '0;
      end else begin
        pos_d = pos_q + TotW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      total_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      total_q     <= total_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_count) byte_addr_q <= byte_addr;
    if (ctrl_i.read_count_sym) sym_q <= ord_rdata;
    if (ctrl_i.load_empty) begin
      res_symbol_q <= '0;
      res_count_q  <= '0;
      res_valid_q  <= 1'b0;
      res_last_q   <= 1'b0;
    end else if (ctrl_i.finish_report) begin
      res_symbol_q <= sym_q;
      res_count_q  <= cnt_clip;
      res_valid_q  <= 1'b1;
      res_last_q   <= is_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_symbol_o    = res_symbol_q;
  assign out_count_o     = res_count_q;
  assign out_valid_res_o = res_valid_q;
  assign out_last_o      = res_last_q;

endmodule

// File: sv/byte_histogram_core.sv
// ----------------------------------------------------------------------------
// byte_histogram_core
// Byte value histogram kept in first-appearance order.
// ----------------------------------------------------------------------------
// A count transfer (tuser = 0) writes a count of one for a byte not yet
// seen and does a read-modify-write of the count memory for a repeated
// byte; zero bytes and bytes beyond the alphabet are not counted. A report
// transfer (tuser = 1) makes two dependent reads, of the appearance list and
// then of the count memory, and returns one entry, most recently first-seen
// first; tlast marks the final entry, after which the table is empty. A
// report on an empty table returns one transfer with tuser = 0. A count
// transfer restarts the report from the top of the list. No clearing pass
// follows reset.
module byte_histogram_core #(
  parameter int ALPHABET_SIZE = bh_pkg::SymbolCountDefault,
  parameter int COUNT_WIDTH   = bh_pkg::CountWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] byte_value
  input  logic        s_axis_tuser,  // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [7:0] symbol, [39:8] count
  output logic        m_axis_tuser,  // [0] valid_res
  output logic        m_axis_tlast
);
  import bh_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  logic [ByteWidth-1:0]     symbol;
  logic [OutCountWidth-1:0] count;

  bh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  bh_datapath #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .byte_i          (s_axis_tdata),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_symbol_o    (symbol),
    .out_count_o     (count),
    .out_valid_res_o (m_axis_tuser),
    .out_last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {count, symbol};

endmodule
